@@ src/dlts_pkg.sv @@
// shared types and constants of the delta-list task scheduler
// no dependencies; used by every module in src
package dlts_pkg;

  localparam int unsigned DEF_MAX_TASKS = 16;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_DELETE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NONE_DUE  = 2'd3
  } status_e;

  // one list entry, handle zero means empty
  typedef struct packed {
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic        due;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic head_we;
  } ring_ctl_t;

  typedef struct packed {
    logic insert;
    logic rm_head;
    logic first;
    logic last;
    logic placed;
    logic shifting;
    logic removed;
  } step_ctl_t;

  typedef struct packed {
    logic placed;
    logic shifting;
    logic removed;
    logic take_id;
  } step_res_t;

endpackage

@@ src/dlts_ring.sv @@
// ring of list entries that rotates by one place per step, or has its head cell written in place
// depends on dlts_pkg
module dlts_ring import dlts_pkg::*; #(
  parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ring_ctl_t ctl_i,
  input  entry_t    tail_i,
  input  entry_t    head_i,
  output entry_t    head0_o,
  output entry_t    head1_o,
  output entry_t    last_o
);

  entry_t cell_q [MAX_TASKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) cell_q[i] <= '0;
    end else if (ctl_i.shift) begin
      for (int i = 0; i < MAX_TASKS - 1; i++) cell_q[i] <= cell_q[i + 1];
      cell_q[MAX_TASKS - 1] <= tail_i;
    end else if (ctl_i.head_we) begin
      cell_q[0] <= head_i;
    end
  end

  assign head0_o = cell_q[0];
  assign head1_o = cell_q[1];
  assign last_o  = cell_q[MAX_TASKS - 1];

endmodule

@@ src/dlts_step.sv @@
// shared step unit: one entry of an insert or remove pass per cycle
// depends on dlts_pkg
module dlts_step import dlts_pkg::*; (
  input  step_ctl_t   ctl_i,
  input  entry_t      head0_i,
  input  entry_t      head1_i,
  input  entry_t      hold_i,
  input  logic [15:0] sum_i,
  input  logic [7:0]  handle_i,
  input  logic [15:0] delay_i,
  input  logic [15:0] period_i,
  input  logic [15:0] target_i,
  input  logic [15:0] new_id_i,
  output entry_t      wr_o,
  output entry_t      hold_o,
  output logic [15:0] sum_o,
  output step_res_t   res_o
);

  logic [16:0] s;
  logic [16:0] sat_sum;
  logic        occ;
  logic        over;
  logic        match;
  entry_t      ne;

  always_comb begin
    occ     = head0_i.handle != '0;
    s       = {1'b0, sum_i} + {1'b0, head0_i.delay};
    over    = s > {1'b0, delay_i};
    sat_sum = {1'b0, head1_i.delay} + {1'b0, head0_i.delay};
    match   = !ctl_i.removed && occ &&
              (ctl_i.rm_head ? ctl_i.first : (head0_i.id == target_i));

    ne.handle = handle_i;
    ne.period = period_i;
    ne.id     = new_id_i;
    ne.delay  = delay_i - (over ? sum_i : s[15:0]);
    ne.due    = ne.delay == '0;

    wr_o           = head0_i;
    hold_o         = hold_i;
    sum_o          = sum_i;
    res_o.placed   = ctl_i.placed;
    res_o.shifting = ctl_i.shifting;
    res_o.removed  = ctl_i.removed;
    res_o.take_id  = 1'b0;

    if (ctl_i.insert) begin
      if (ctl_i.placed && ctl_i.shifting) begin
        wr_o   = hold_i;
        hold_o = head0_i;
      end else if (ctl_i.placed) begin
        wr_o = head0_i;
      end else if (over) begin
        // insert ahead of this entry, which moves down with its delay cut by the new entry's delay
        wr_o           = ne;
        hold_o         = head0_i;
        hold_o.delay   = 16'(s - {1'b0, delay_i});
        res_o.placed   = 1'b1;
        res_o.shifting = 1'b1;
        res_o.take_id  = 1'b1;
      end else if (!occ) begin
        wr_o          = ne;
        res_o.placed  = 1'b1;
        res_o.take_id = 1'b1;
      end else begin
        sum_o = s[15:0];
      end
    end else begin
      if (match) begin
        res_o.removed = 1'b1;
        if (ctl_i.last) begin
          wr_o = '0;
        end else begin
          wr_o = head1_i;
          if (head1_i.handle != '0) begin
            wr_o.delay = sat_sum[16] ? 16'hFFFF : sat_sum[15:0];
            wr_o.due   = sat_sum == '0;
          end
        end
      end else if (ctl_i.removed) begin
        wr_o = ctl_i.last ? entry_t'('0) : head1_i;
      end
    end
  end

endmodule

@@ src/delta_list_task_scheduler_top.sv @@
// top level of the delta-list task scheduler: sequencer, handshakes, result register
// depends on dlts_pkg, dlts_ring and dlts_step
module delta_list_task_scheduler_top import dlts_pkg::*; #(
  parameter int unsigned MAX_TASKS = DEF_MAX_TASKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  task_handle_i,
  input  logic [15:0] delay_ticks_i,
  input  logic [15:0] period_ticks_i,
  input  logic [15:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] assigned_id_o,
  output logic [7:0]  fired_handle_o
);

  // The scheduler holds up to MAX_TASKS timed tasks as a delta list in a ring
  // of entry registers. Add and delete work as one pass over the ring: the ring
  // rotates by one place per cycle, and a single shared step unit (two adds, two
  // subtracts, a delay and an id compare) looks at the two head places and
  // decides what enters at the tail, so entries are inserted, dropped and
  // shifted on the fly. After an input transfer a request goes through S_START,
  // where a tick updates the head and rejected or trivial requests are settled;
  // add, delete and a one-shot dispatch then make one pass, and a dispatch of a
  // periodic task makes a remove pass, then a re-insert pass; S_FIN then loads
  // the result into the output register. The next request can be taken in the
  // same cycle as the result appears. The pass length is set by the ring
  // rotation through the one step unit. The input stalls while a request
  // is in progress, and a finished request also waits while an earlier result
  // is still stalled in the output register; otherwise the result sits in the
  // output register and a new request is taken while it waits for its transfer.

  localparam int unsigned CntW = $clog2(MAX_TASKS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_START  = 5'b00010,
    S_REMOVE = 5'b00100,
    S_INSERT = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  op_e               op_q, op_d;
  logic [7:0]        handle_q, handle_d;
  logic [15:0]       delay_q, delay_d;
  logic [15:0]       period_q, period_d;
  logic [15:0]       target_q, target_d;
  logic              rm_head_q, rm_head_d;
  logic [15:0]       sum_q, sum_d;
  entry_t            hold_q, hold_d;
  logic              placed_q, placed_d;
  logic              shifting_q, shifting_d;
  logic              removed_q, removed_d;
  logic [15:0]       last_id_q, last_id_d;
  status_e           res_status_q, res_status_d;
  logic [15:0]       res_id_q, res_id_d;
  logic [7:0]        res_fired_q, res_fired_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [15:0]       out_id_q, out_id_d;
  logic [7:0]        out_fired_q, out_fired_d;

  ring_ctl_t   ring_ctl;
  entry_t      head0, head1, last_entry, tick_entry;
  step_ctl_t   step_ctl;
  step_res_t   step_res;
  entry_t      step_wr, step_hold;
  logic [15:0] step_sum;
  logic [15:0] new_id;
  logic        cnt_last;

  dlts_ring #(.MAX_TASKS(MAX_TASKS)) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ring_ctl),
    .tail_i  (step_wr),
    .head_i  (tick_entry),
    .head0_o (head0),
    .head1_o (head1),
    .last_o  (last_entry)
  );

  dlts_step u_step (
    .ctl_i    (step_ctl),
    .head0_i  (head0),
    .head1_i  (head1),
    .hold_i   (hold_q),
    .sum_i    (sum_q),
    .handle_i (handle_q),
    .delay_i  (delay_q),
    .period_i (period_q),
    .target_i (target_q),
    .new_id_i (new_id),
    .wr_o     (step_wr),
    .hold_o   (step_hold),
    .sum_o    (step_sum),
    .res_o    (step_res)
  );

  // new ids count up and skip zero
  assign new_id   = (last_id_q == 16'hFFFF) ? 16'd1 : last_id_q + 16'd1;
  assign cnt_last = cnt_q == CntW'(MAX_TASKS - 1);

  always_comb begin
    step_ctl.insert   = state_q == S_INSERT;
    step_ctl.rm_head  = rm_head_q;
    step_ctl.first    = cnt_q == '0;
    step_ctl.last     = cnt_last;
    step_ctl.placed   = placed_q;
    step_ctl.shifting = shifting_q;
    step_ctl.removed  = removed_q;

    // tick: count the head down and mark it due at zero
    tick_entry       = head0;
    tick_entry.delay = (head0.delay != '0) ? head0.delay - 16'd1 : head0.delay;
    tick_entry.due   = tick_entry.delay == '0;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    handle_d     = handle_q;
    delay_d      = delay_q;
    period_d     = period_q;
    target_d     = target_q;
    rm_head_d    = rm_head_q;
    sum_d        = sum_q;
    hold_d       = hold_q;
    placed_d     = placed_q;
    shifting_d   = shifting_q;
    removed_d    = removed_q;
    last_id_d    = last_id_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_fired_d  = res_fired_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    out_id_d     = out_id_q;
    out_fired_d  = out_fired_q;
    ring_ctl     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_e'(mode_i);
          handle_d     = task_handle_i;
          delay_d      = delay_ticks_i;
          period_d     = period_ticks_i;
          target_d     = target_id_i;
          res_status_d = ST_OK;
          res_id_d     = '0;
          res_fired_d  = '0;
          state_d      = S_START;
        end
      end
      S_START: begin
        cnt_d      = '0;
        sum_d      = '0;
        placed_d   = 1'b0;
        shifting_d = 1'b0;
        removed_d  = 1'b0;
        state_d    = S_FIN;
        unique case (op_q)
          OP_TICK: begin
            ring_ctl.head_we = (head0.handle != '0) && !head0.due;
          end
          OP_ADD: begin
            if (handle_q == '0) begin
              res_status_d = ST_OK;
            end else if (last_entry.handle != '0) begin
              res_status_d = ST_FULL;
            end else begin
              state_d = S_INSERT;
            end
          end
          OP_DISPATCH: begin
            if ((head0.handle != '0) && head0.due) begin
              // pop the head, then re-add it with its period if periodic
              res_fired_d = head0.handle;
              handle_d    = head0.handle;
              delay_d     = head0.period;
              period_d    = head0.period;
              rm_head_d   = 1'b1;
              state_d     = S_REMOVE;
            end else begin
              res_status_d = ST_NONE_DUE;
            end
          end
          OP_DELETE: begin
            if (target_q == '0) begin
              res_status_d = ST_NOT_FOUND;
            end else begin
              rm_head_d = 1'b0;
              state_d   = S_REMOVE;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_REMOVE: begin
        ring_ctl.shift = 1'b1;
        removed_d      = step_res.removed;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_last) begin
          cnt_d = '0;
          if ((op_q == OP_DISPATCH) && (period_q != '0)) begin
            sum_d      = '0;
            placed_d   = 1'b0;
            shifting_d = 1'b0;
            state_d    = S_INSERT;
          end else begin
            res_status_d = ((op_q == OP_DELETE) && !step_res.removed) ? ST_NOT_FOUND : ST_OK;
            state_d      = S_FIN;
          end
        end
      end
      S_INSERT: begin
        ring_ctl.shift = 1'b1;
        hold_d         = step_hold;
        sum_d          = step_sum;
        placed_d       = step_res.placed;
        shifting_d     = step_res.shifting;
        cnt_d          = cnt_q + CntW'(1);
        if (step_res.take_id) begin
          last_id_d = new_id;
          res_id_d  = new_id;
        end
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // wait for a free result register
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          out_id_d    = res_id_q;
          out_fired_d = res_fired_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rm_head_q   <= 1'b0;
      placed_q    <= 1'b0;
      shifting_q  <= 1'b0;
      removed_q   <= 1'b0;
      last_id_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rm_head_q   <= rm_head_d;
      placed_q    <= placed_d;
      shifting_q  <= shifting_d;
      removed_q   <= removed_d;
      last_id_q   <= last_id_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    handle_q     <= handle_d;
    delay_q      <= delay_d;
    period_q     <= period_d;
    target_q     <= target_d;
    sum_q        <= sum_d;
    hold_q       <= hold_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_fired_q  <= res_fired_d;
    status_q     <= status_d;
    out_id_q     <= out_id_d;
    out_fired_q  <= out_fired_d;
  end

  assign in_stall_o     = state_q != S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign assigned_id_o  = out_id_q;
  assign fired_handle_o = out_fired_q;

endmodule
